/* hdl/uvs_pkg.sv */
// uvs_pkg: shared types and constants of the unique value stack.
// No dependencies; imported by the channel interfaces and the core.
`default_nettype none

package uvs_pkg;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 16;
    localparam int RESULT_W = 16;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 3'd0,
        FN_POP    = 3'd1,
        FN_PEEK   = 3'd2,
        FN_REMOVE = 3'd3,
        FN_FIND   = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_DUP     = 3'd3,
        ST_MISSING = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_TOP_RD,
        S_TOP_WAIT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

/* hdl/uvs_if.sv */
// uvs_in_if / uvs_out_if: valid/ready channels of the unique value stack.
// Depends on uvs_pkg for the field widths.
`default_nettype none

interface uvs_in_if import uvs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface uvs_out_if import uvs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] result_value;
    logic [POS_W-1:0]    position;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;

    modport source (output valid, output result_value, output position, output found,
                    output status, output entry_count, output is_empty, input ready);
    modport sink   (input valid, input result_value, input position, input found,
                    input status, input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

/* hdl/unique_value_stack_core.sv */
// unique_value_stack_core: stack of distinct values with remove and find by value.
// Depends on uvs_pkg and on uvs_in_if / uvs_out_if.
//
//  - i_in carries one command word per handshake (func, value); o_out returns
//    one result word per command (result_value, position, found, status,
//    entry_count, is_empty).
//  - Entries live in one memory with a registered read. Push, remove
//    and find walk the stored entries from the bottom, one read per cycle.
//  - From command accept to the result in the output register: pop / peek
//    read the top entry (no read when empty), push / find scan until a hit
//    or the fill count, remove scans and then shifts the entries above the hit
//    down (search and shift together walk the entries once through the one
//    read port), unused func codes go straight to the result. The next
//    command is taken the cycle after the result is loaded.
//  - i_in.ready is high only while the sequencer is idle, so the next command
//    is taken while the previous result still waits in the output register.
//    If the receiver stalls, the following result is held in the sequencer
//    until the output register frees up.
//  - Synchronous active-low reset empties the stack and drops a pending result;
//    memory is not cleared, only entries below the fill count are read.
`default_nettype none

module unique_value_stack_core
    import uvs_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    uvs_in_if.sink     i_in,
    uvs_out_if.source  o_out
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // entry storage
    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    // sequencer state
    t_state                 r_state, n_state;
    t_func                  r_func, n_func;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_addr, n_addr;   // next address to read
    logic                   r_pend, n_pend;   // read in flight
    logic [IDX_W-1:0]       r_pidx, n_pidx;   // address of read in flight
    logic [VALUE_WIDTH-1:0] r_rd_data;

    // result under construction
    logic [VALUE_WIDTH-1:0] r_res, n_res;
    logic [IDX_W-1:0]       r_pos, n_pos;
    logic                   r_fnd, n_fnd;
    t_status                r_status, n_status;

    // output register
    logic                r_o_valid, n_o_valid;
    logic [RESULT_W-1:0] r_o_res;
    logic [POS_W-1:0]    r_o_pos;
    logic                r_o_fnd;
    t_status             r_o_status;
    logic [COUNT_W-1:0]  r_o_count;
    logic                r_o_empty;

    // memory port controls
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    logic                   accept;
    logic                   can_emit;
    logic                   load_out;
    logic                   hit;
    logic                   scan_end;
    logic [31:0]            in_ext;
    logic [31:0]            res_ext;
    logic [31:0]            pos_ext;
    logic [31:0]            cnt_ext;

    assign accept   = i_in.valid && i_in.ready;
    assign can_emit = !r_o_valid || o_out.ready;
    assign load_out = (r_state == S_EMIT) && can_emit;
    assign hit      = r_pend && (r_rd_data == r_val);
    assign scan_end = !hit && (r_addr == r_count);
    assign in_ext   = 32'(i_in.value);
    assign res_ext  = 32'(r_res);
    assign pos_ext  = 32'(r_pos);
    assign cnt_ext  = 32'(r_count);

    assign i_in.ready = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_func'(i_in.func))
                        FN_PUSH, FN_REMOVE, FN_FIND: n_state = S_SCAN;
                        FN_POP, FN_PEEK:             n_state = S_TOP_RD;
                        default:                     n_state = S_EMIT;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = (r_func == FN_REMOVE) ? S_SHIFT : S_EMIT;
                end else if (scan_end) begin
                    n_state = S_EMIT;
                end
            end
            S_SHIFT: begin
                if (r_addr == r_count) begin
                    n_state = S_EMIT;
                end
            end
            S_TOP_RD: begin
                n_state = (r_count == '0) ? S_EMIT : S_TOP_WAIT;
            end
            S_TOP_WAIT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (can_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_func   = r_func;
        n_val    = r_val;
        n_count  = r_count;
        n_addr   = r_addr;
        n_pend   = 1'b0;
        n_pidx   = r_pidx;
        n_res    = r_res;
        n_pos    = r_pos;
        n_fnd    = r_fnd;
        n_status = r_status;
        rd_en    = 1'b0;
        rd_addr  = r_addr[IDX_W-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_count[IDX_W-1:0];
        wr_data  = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func   = t_func'(i_in.func);
                    n_val    = in_ext[VALUE_WIDTH-1:0];
                    n_addr   = '0;
                    n_res    = '0;
                    n_pos    = '0;
                    n_fnd    = 1'b0;
                    n_status = ST_OK;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    case (r_func)
                        FN_PUSH: n_status = ST_DUP;
                        FN_REMOVE: begin
                            n_res  = r_val;
                            n_addr = CNT_W'(r_pidx) + CNT_W'(1);
                        end
                        default: begin
                            n_res = r_val;
                            n_pos = r_pidx;
                            n_fnd = 1'b1;
                        end
                    endcase
                end else if (scan_end) begin
                    if (r_func == FN_PUSH) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_res   = r_val;
                        end
                    end else begin
                        n_status = ST_MISSING;
                    end
                end else begin
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_addr[IDX_W-1:0];
                    n_addr = r_addr + CNT_W'(1);
                end
            end
            S_SHIFT: begin
                // entry at r_pidx moves down one slot
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pidx - IDX_W'(1);
                    wr_data = r_rd_data;
                end
                if (r_addr == r_count) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_addr[IDX_W-1:0];
                    n_addr = r_addr + CNT_W'(1);
                end
            end
            S_TOP_RD: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(r_count - CNT_W'(1));
                end
            end
            S_TOP_WAIT: begin
                n_res = r_rd_data;
                if (r_func == FN_POP) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // output register handshake
    always_comb begin
        n_o_valid = r_o_valid;
        if (o_out.ready) begin
            n_o_valid = 1'b0;
        end
        if (load_out) begin
            n_o_valid = 1'b1;
        end
    end

    // memory: registered read, synchronous write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_val    <= n_val;
        r_addr   <= n_addr;
        r_pidx   <= n_pidx;
        r_res    <= n_res;
        r_pos    <= n_pos;
        r_fnd    <= n_fnd;
        r_status <= n_status;
        if (load_out) begin
            r_o_res    <= res_ext[RESULT_W-1:0];
            r_o_pos    <= pos_ext[POS_W-1:0];
            r_o_fnd    <= r_fnd;
            r_o_status <= r_status;
            r_o_count  <= cnt_ext[COUNT_W-1:0];
            r_o_empty  <= (r_count == '0);
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.result_value = r_o_res;
    assign o_out.position     = r_o_pos;
    assign o_out.found        = r_o_fnd;
    assign o_out.status       = r_o_status;
    assign o_out.entry_count  = r_o_count;
    assign o_out.is_empty     = r_o_empty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && (r_state == S_IDLE || r_state == S_EMIT)))
        else $error("memory write outside an operation");

    a_bad_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != ST_OK) |-> (r_o_res == '0 && !r_o_fnd))
        else $error("failed operation returned a value");

    a_shift_read_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend && rd_en) |-> (rd_addr != wr_addr))
        else $error("shift read collides with write");

    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_state == S_IDLE && r_o_valid))
        else $error("result not held after load");
`endif

endmodule

`default_nettype wire
